/* hw/rtl/phac_pkg.sv */
// Shared types and constants for the packet header Adler check block.
// Used by phac_core and packet_header_adler_check_top; depends on nothing.
package phac_pkg;

  // Header layout, as byte offsets into the packet.
  localparam logic [3:0] HDR_BYTES  = 4'd9;
  localparam logic [3:0] TYPE_OFS   = 4'd4;
  localparam logic [3:0] SESS_OFS   = 4'd5;

  // Adler-32 modulus and the reset value of the low sum.
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] LO_RESET  = 16'd1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SHORT    = 2'd1,
    STAT_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  msg_type;
    logic [31:0] conn_id;
    logic [31:0] checksum_field;
  } result_t;

endpackage

/* hw/rtl/phac_core.sv */
// Per-byte state of the header check: byte count, header fields, Adler sums.
// Forms the result for a final byte. Depends on phac_pkg.
module phac_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output phac_pkg::result_t result
);

  logic [3:0]  count_r, count_nxt;
  logic [31:0] chk_r, chk_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [15:0] lo_r, lo_nxt;
  logic [15:0] hi_r, hi_nxt;

  logic [16:0] lo_sum;
  logic [16:0] hi_sum;
  logic [3:0]  sess_pos;
  logic        in_sums;

  always_comb begin
    in_sums   = (count_r >= phac_pkg::TYPE_OFS);
    count_nxt = (count_r < phac_pkg::HDR_BYTES) ? count_r + 4'd1 : phac_pkg::HDR_BYTES;
    sess_pos  = count_r - phac_pkg::SESS_OFS;

    chk_nxt  = chk_r;
    type_nxt = type_r;
    sess_nxt = sess_r;
    if (!in_sums) begin
      chk_nxt[{count_r[1:0], 3'b000} +: 8] = data_byte;
    end else if (count_r == phac_pkg::TYPE_OFS) begin
      type_nxt = data_byte;
    end else if (count_r < phac_pkg::HDR_BYTES) begin
      sess_nxt[{sess_pos[1:0], 3'b000} +: 8] = data_byte;
    end

    // Both sums stay below the modulus, so one conditional subtract suffices.
    lo_sum = {1'b0, lo_r} + {9'd0, data_byte};
    if (lo_sum >= phac_pkg::ADLER_MOD) begin
      lo_sum = lo_sum - phac_pkg::ADLER_MOD;
    end
    hi_sum = {1'b0, hi_r} + {1'b0, lo_sum[15:0]};
    if (hi_sum >= phac_pkg::ADLER_MOD) begin
      hi_sum = hi_sum - phac_pkg::ADLER_MOD;
    end
    lo_nxt = in_sums ? lo_sum[15:0] : lo_r;
    hi_nxt = in_sums ? hi_sum[15:0] : hi_r;

    result = '0;
    if (count_nxt < phac_pkg::HDR_BYTES) begin
      result.status = phac_pkg::STAT_SHORT;
    end else if ({hi_nxt, lo_nxt} != chk_nxt) begin
      result.status = phac_pkg::STAT_MISMATCH;
    end else begin
      result.status         = phac_pkg::STAT_OK;
      result.msg_type       = type_nxt;
      result.conn_id        = sess_nxt;
      result.checksum_field = chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      count_r <= '0;
      chk_r   <= '0;
      type_r  <= '0;
      sess_r  <= '0;
      lo_r    <= phac_pkg::LO_RESET;
      hi_r    <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      chk_r   <= chk_nxt;
      type_r  <= type_nxt;
      sess_r  <= sess_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

/* hw/rtl/packet_header_adler_check_top.sv */
// Top level of the packet header Adler check: input register, checker core,
// result register. Depends on phac_pkg and phac_core.
//
// The block takes a received packet one byte per beat on the input channel,
// with in_last_byte marking the final byte, and returns one result beat per
// packet. A packet opens with a nine-byte header: a little-endian 32-bit
// checksum, a type byte and a little-endian 32-bit session id. Adler-32 sums
// (low starting at 1, high at 0, both modulo 65521) run over every byte from
// offset 4 to the end. The result status is success, packet shorter than the
// header, or checksum mismatch; type, session id and checksum are reported
// only on success and are zero otherwise. After each final byte the block is
// back in its reset state for the next packet. Throughput is one byte per
// clock cycle, except that a final byte is held while the result register
// still holds an untaken result. A byte sits in an input register while the
// core updates its sums (an add and conditional subtract for each of the
// two sums, chained); the result of a final byte is written into the output
// register as the byte leaves the input register, and out_valid then rises.
// While a result waits for out_ready, bytes that do not end a packet keep
// flowing; a second final byte waits in the input register.
module packet_header_adler_check_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_msg_type,
  output logic [31:0] out_conn_id,
  output logic [31:0] out_checksum_field
);

  // Input register stage.
  logic       s_valid_r;
  logic [7:0] s_data_r;
  logic       s_last_r;
  logic       s_go;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  phac_pkg::result_t res_r;
  phac_pkg::result_t core_res;

  // A staged byte moves on unless it ends a packet and the result register
  // is still occupied by an untaken result.
  assign s_go     = s_valid_r && (!s_last_r || !out_valid_r || out_ready);
  assign in_ready = !s_valid_r || s_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data_r <= in_data_byte;
      s_last_r <= in_last_byte;
    end
  end

  phac_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s_go),
    .data_byte (s_data_r),
    .last_byte (s_last_r),
    .result    (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s_go && s_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_last_r) begin
      res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_msg_type       = res_r.msg_type;
  assign out_conn_id        = res_r.conn_id;
  assign out_checksum_field = res_r.checksum_field;

`ifndef SYNTHESIS
  // A failed check never reports header fields.
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != phac_pkg::STAT_OK) |->
      (res_r.msg_type == 8'd0) && (res_r.conn_id == 32'd0) &&
      (res_r.checksum_field == 32'd0))
    else $error("failed result carries header fields");

  // A waiting result is never overwritten by the next packet's result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s_go && s_last_r))
    else $error("result register overwritten while held");

  // Back-pressure on the input only comes from a byte held in the stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s_valid_r && s_last_r && out_valid_r && !out_ready)
    else $error("input stalled without a held final byte");
`endif

endmodule
